@@ hw/rtl/cidr_random_address_draw_core_macros.svh @@
// ----------------------------------------------------------------------------
// CIDR random address draw: assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef CIDR_RANDOM_ADDRESS_DRAW_CORE_MACROS_SVH
`define CIDR_RANDOM_ADDRESS_DRAW_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define CIDR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond in one cycle implies rhs in the next
`define CIDR_ASSERT_NEXT(label, clk, rst, cond, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (rhs)) else $error(msg);

`else

`define CIDR_ASSERT(label, clk, rst, prop, msg)
`define CIDR_ASSERT_NEXT(label, clk, rst, cond, rhs, msg)

`endif

`endif

@@ hw/rtl/cidr_pkg.sv @@
// ----------------------------------------------------------------------------
// CIDR random address draw package
// Widths, codes and types shared by the draw core and its remainder unit.
// ----------------------------------------------------------------------------
package cidr_pkg;

   localparam int POOL_DEPTH_DEFAULT = 256;

   localparam int ADDR_W     = 32;
   localparam int RAND_W     = 32;
   localparam int PREFIX_W   = 6;
   localparam int REMAIN_W   = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int SPAN_W     = 25;   // 2^24 is the largest block span (prefix 8)
   localparam int DIV_STEPS  = RAND_W;

   localparam logic [ADDR_W-1:0]   ALL_ONES        = {ADDR_W{1'b1}};
   localparam logic [PREFIX_W-1:0] MAX_PREFIX      = PREFIX_W'(32);
   localparam logic [PREFIX_W-1:0] MIN_MASK_PREFIX = PREFIX_W'(8);
   localparam logic [CSR_DATA_W-1:0] PREFIX_RESET  = CSR_DATA_W'(32);

   typedef enum logic {
      MODE_RESTART = 1'b0,
      MODE_DRAW    = 1'b1
   } mode_type;

   typedef enum logic {
      CSR_BASE_HOST  = 1'b0,
      CSR_PREFIX_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DIV,
      ST_RD_IDX,
      ST_RD_LAST,
      ST_SWAP
   } state_type;

endpackage

@@ hw/rtl/cidr_random_address_draw_core.sv @@
// ----------------------------------------------------------------------------
// CIDR random address draw core
// Hands out addresses of an IPv4 CIDR block once each, in random order, by
// swap-and-remove draws from an offset pool of at most POOL_DEPTH entries.
// ----------------------------------------------------------------------------
//
//   channel   handshake                         payload
//   --------  --------------------------------  -------------------------------
//   request   start & !busy                     req_mode, req_random_value
//   response  rsp_valid (one-cycle strobe)      rsp_address, rsp_found,
//                                               rsp_remaining
//   csr       psel & penable & pwrite & pready  paddr, pwdata (prdata on read)
//
// Sequence: a draw runs the 32-step serial remainder (random mod pool count),
//   then two pool reads and a write before the result strobe. A restart
//   writes one pool entry per offset. A draw on an empty pool answers on the
//   next cycle.
// Reset: synchronous; clears the pool count, state and csr registers. The
//   pool memory is not cleared; only entries below the count are ever read.
// Stalls: the response side cannot stall; busy stays high until the result
//   strobe is issued, and a new transaction may start in the strobe cycle.
//
// csr map: 0x0 base_host (32b), 0x4 prefix_len (6b). Write only while idle.
// ----------------------------------------------------------------------------
`include "cidr_random_address_draw_core_macros.svh"

module cidr_random_address_draw_core import cidr_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [RAND_W-1:0]     req_random_value,
   // response
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_address,
   output logic                  rsp_found,
   output logic [REMAIN_W-1:0]   rsp_remaining,
   // csr
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // pool index / offset width and count width (count may equal POOL_DEPTH)
   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);

   // ------------------------------------------------------------------
   // csr registers
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]   base_host_ff;
   logic [PREFIX_W-1:0] prefix_len_ff;
   logic                csr_wr;
   csr_index_type       csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_host_ff  <= '0;
         prefix_len_ff <= PREFIX_RESET[PREFIX_W-1:0];
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_BASE_HOST:  base_host_ff  <= pwdata[ADDR_W-1:0];
            CSR_PREFIX_LEN: prefix_len_ff <= pwdata[PREFIX_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_BASE_HOST:  prdata = base_host_ff;
         CSR_PREFIX_LEN: prdata = {{(CSR_DATA_W-PREFIX_W){1'b0}}, prefix_len_ff};
         default:        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // block geometry from the current prefix
   // ------------------------------------------------------------------
   logic [PREFIX_W-1:0] eff_prefix;
   logic [PREFIX_W-1:0] host_bits;
   logic [SPAN_W-1:0]   span;
   logic [CNT_W-1:0]    restart_count;
   logic [ADDR_W-1:0]   block_base;

   // prefixes above 32 act as /32
   assign eff_prefix = (prefix_len_ff > MAX_PREFIX) ? MAX_PREFIX : prefix_len_ff;
   assign host_bits  = MAX_PREFIX - eff_prefix;
   assign span       = SPAN_W'(1) << host_bits;

   always_comb begin
      if (eff_prefix < MIN_MASK_PREFIX)
         restart_count = CNT_W'(1);
      else if (span > SPAN_W'(POOL_DEPTH))
         restart_count = CNT_W'(POOL_DEPTH);   // keep only the first entries
      else
         restart_count = span[CNT_W-1:0];
   end

   // short prefixes fall back to the unmasked host address
   assign block_base = (eff_prefix < MIN_MASK_PREFIX) ? base_host_ff
                                                      : base_host_ff & ~(ALL_ONES >> eff_prefix);

   // ------------------------------------------------------------------
   // offset pool memory: one write port, one registered read port
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] pool_ff [POOL_DEPTH];
   logic [IDX_W-1:0] pool_rd_ff;
   logic             mem_wr;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [IDX_W-1:0] mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;

   always_ff @(posedge clock) begin
      if (mem_wr)
         pool_ff[mem_wr_addr] <= mem_wr_data;
      pool_rd_ff <= pool_ff[mem_rd_addr];
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   state_type         state_ff,      state_in;
   logic [CNT_W-1:0]  pool_count_ff, pool_count_in;
   logic [CNT_W-1:0]  fill_cnt_ff,   fill_cnt_in;
   logic [IDX_W-1:0]  fill_ptr_ff,   fill_ptr_in;
   logic [IDX_W-1:0]  idx_ff,        idx_in;
   logic [IDX_W-1:0]  sel_off_ff,    sel_off_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic [ADDR_W-1:0] rsp_address_ff, rsp_address_in;
   logic              rsp_found_ff,  rsp_found_in;
   logic [CNT_W-1:0]  rsp_count_ff,  rsp_count_in;

   logic             accept;
   logic [CNT_W-1:0] count_dec;
   logic [IDX_W-1:0] last_idx;

   assign accept    = start & ~busy;
   assign count_dec = pool_count_ff - 1'b1;
   assign last_idx  = count_dec[IDX_W-1:0];

   // ------------------------------------------------------------------
   // serial remainder unit: random_value mod pool count
   // ------------------------------------------------------------------
   logic             rem_start;
   logic             rem_done;
   logic [CNT_W-1:0] rem_value;

   cidr_rem_unit #(
      .CNT_W (CNT_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_random_value),
      .divisor   (pool_count_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      state_in       = state_ff;
      pool_count_in  = pool_count_ff;
      fill_cnt_in    = fill_cnt_ff;
      fill_ptr_in    = fill_ptr_ff;
      idx_in         = idx_ff;
      sel_off_in     = sel_off_ff;
      rsp_valid_in   = 1'b0;
      rsp_address_in = rsp_address_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      rem_start      = 1'b0;
      mem_wr         = 1'b0;
      mem_wr_addr    = fill_ptr_ff;
      mem_wr_data    = fill_ptr_ff;
      mem_rd_addr    = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_type'(req_mode) == MODE_RESTART) begin
                  fill_cnt_in = restart_count;
                  fill_ptr_in = '0;
                  state_in    = ST_FILL;
               end else if (pool_count_ff != '0) begin
                  rem_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  // empty pool: answer at once, nothing drawn
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = '0;
                  rsp_found_in   = 1'b0;
                  rsp_count_in   = '0;
               end
            end
         end

         ST_FILL: begin
            // pool[i] = i, one entry per cycle
            mem_wr      = 1'b1;
            fill_ptr_in = fill_ptr_ff + 1'b1;
            if (CNT_W'(fill_ptr_ff) == fill_cnt_ff - 1'b1) begin
               pool_count_in  = fill_cnt_ff;
               rsp_valid_in   = 1'b1;
               rsp_address_in = '0;
               rsp_found_in   = 1'b0;
               rsp_count_in   = fill_cnt_ff;
               state_in       = ST_IDLE;
            end
         end

         ST_DIV: begin
            if (rem_done) begin
               idx_in   = rem_value[IDX_W-1:0];
               state_in = ST_RD_IDX;
            end
         end

         ST_RD_IDX: begin
            mem_rd_addr = idx_ff;       // picked entry
            state_in    = ST_RD_LAST;
         end

         ST_RD_LAST: begin
            mem_rd_addr = last_idx;     // last entry, moves into the hole
            sel_off_in  = pool_rd_ff;
            state_in    = ST_SWAP;
         end

         ST_SWAP: begin
            mem_wr         = 1'b1;
            mem_wr_addr    = idx_ff;
            mem_wr_data    = pool_rd_ff;
            pool_count_in  = count_dec;
            rsp_valid_in   = 1'b1;
            rsp_address_in = block_base + ADDR_W'(sel_off_ff);   // wraps mod 2^32
            rsp_found_in   = 1'b1;
            rsp_count_in   = count_dec;
            state_in       = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_count_ff <= pool_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_cnt_ff    <= fill_cnt_in;
      fill_ptr_ff    <= fill_ptr_in;
      idx_ff         <= idx_in;
      sel_off_ff     <= sel_off_in;
      rsp_address_ff <= rsp_address_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // ------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------
   logic [CNT_W+REMAIN_W-1:0] remain_wide;

   assign remain_wide   = {{REMAIN_W{1'b0}}, rsp_count_ff};
   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_address   = rsp_address_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_remaining = remain_wide[REMAIN_W-1:0];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `CIDR_ASSERT(a_rsp_when_idle, clock, reset, rsp_valid_ff |-> (state_ff == ST_IDLE), "result strobe while sequencer busy")
   `CIDR_ASSERT(a_count_in_range, clock, reset, (pool_count_ff <= CNT_W'(POOL_DEPTH)), "pool count above pool depth")
   `CIDR_ASSERT_NEXT(a_empty_draw, clock, reset, accept && req_mode && (pool_count_ff == '0), rsp_valid_ff && !rsp_found_ff, "empty draw did not answer not found")
   `CIDR_ASSERT(a_found_decrements, clock, reset, (rsp_valid_ff && rsp_found_ff) |-> (({1'b0, pool_count_ff} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, $past(pool_count_ff)}), "draw did not remove one entry")
   `CIDR_ASSERT(a_count_stable_div, clock, reset, (state_ff == ST_DIV) |-> $stable(pool_count_ff), "divisor changed during remainder")

endmodule

@@ hw/rtl/cidr_rem_unit.sv @@
// ----------------------------------------------------------------------------
// CIDR remainder unit
// Restoring bit-serial remainder: 32-bit dividend, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "cidr_random_address_draw_core_macros.svh"

module cidr_rem_unit import cidr_pkg::*; #(
   parameter int CNT_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAND_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,   // held stable while running
   output logic             done,
   output logic [CNT_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAND_W-1:0] num_ff,  num_in;
   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   assign trial = {rem_ff, num_ff[RAND_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
      end else if (run_ff) begin
         num_in  = {num_ff[RAND_W-2:0], 1'b0};
         rem_in  = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `CIDR_ASSERT(a_rem_below_divisor, clock, reset, done_ff |-> (rem_ff < divisor), "remainder not below divisor")
   `CIDR_ASSERT(a_done_after_run, clock, reset, done_ff |-> ($past(run_ff) && !run_ff), "done without a finished run")
   `CIDR_ASSERT(a_no_restart_midrun, clock, reset, run_ff |-> !start, "start while remainder unit busy")

endmodule

@@ tb/tb_cidr_random_address_draw_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIDR random address draw core testbench
// Drives restart and draw transactions into the core, predicts each response
// from a shadow copy of the offset pool and the csr registers, and checks every
// strobed response field by field. Runs directed corner cases first, then
// random phases across a spread of prefix lengths, base addresses and sender
// idle rates. Registers are rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_cidr_random_address_draw_core;
   import cidr_pkg::*;

   localparam int DEPTH          = POOL_DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4000;  // well above a full pool refill
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 123;

   typedef struct {
      mode_type          mode;
      logic [RAND_W-1:0] rnd;
   } draw_request_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic                found;
      logic [REMAIN_W-1:0] remaining;
   } draw_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic              start            = 1'b0;
   logic              busy;
   logic              req_mode         = 1'b0;
   logic [RAND_W-1:0] req_random_value = '0;

   // response channel
   logic                rsp_valid;
   logic [ADDR_W-1:0]   rsp_address;
   logic                rsp_found;
   logic [REMAIN_W-1:0] rsp_remaining;

   // csr port
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // stimulus and scoreboard
   draw_request_type request_q[$];   // transactions not yet handed to the core
   draw_result_type  answer_q[$];    // predicted responses, oldest first
   draw_result_type  want;
   int               errors      = 0;
   int               idle_pct    = 0;   // sender idle chance, percent per cycle
   int               quiet_count = 0;
   logic             taken       = 1'b0; // request accepted at the last rising edge

   // shadow state of the core
   logic [ADDR_W-1:0]   host_reg   = '0;
   logic [PREFIX_W-1:0] prefix_reg = MAX_PREFIX;
   logic [7:0]          pool_offset [DEPTH];
   logic [REMAIN_W-1:0] undrawn    = '0;

   cidr_random_address_draw_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_address      (rsp_address),
      .rsp_found        (rsp_found),
      .rsp_remaining    (rsp_remaining),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // Shadow model of one transaction: updates the pool and returns the
   // response the core must strobe for it.
   function automatic draw_result_type predict_draw(mode_type mode, logic [RAND_W-1:0] rnd);
      draw_result_type   r;
      logic [5:0]        p;
      logic [ADDR_W-1:0] blk;
      longint unsigned   span;
      int unsigned       slot;
      r = '0;
      // prefixes above 32 behave as 32
      p = (prefix_reg > MAX_PREFIX) ? MAX_PREFIX : prefix_reg;
      if (mode == MODE_RESTART) begin
         if (p < MIN_MASK_PREFIX) begin
            span = 1;
         end else begin
            span = 64'd1 << (32 - p);
         end
         if (span > DEPTH) begin
            span = DEPTH;
         end
         for (int i = 0; i < span; i++) begin
            pool_offset[i] = 8'(i);
         end
         undrawn = REMAIN_W'(span);
      end else if (undrawn != 0) begin
         slot = rnd % undrawn;
         // short prefixes use the base unmasked
         if (p < MIN_MASK_PREFIX) begin
            blk = host_reg;
         end else begin
            blk = host_reg & ~(ALL_ONES >> p);
         end
         r.address         = blk + ADDR_W'(pool_offset[slot]);   // wraps mod 2^32
         pool_offset[slot] = pool_offset[undrawn - 1];
         undrawn           = undrawn - 1'b1;
         r.found           = 1'b1;
      end
      r.remaining = undrawn;
      return r;
   endfunction

   function automatic logic [RAND_W-1:0] pick_random_value();
      case ($urandom_range(0, 9))
         0, 1: begin
            return RAND_W'($urandom_range(0, 600));
         end
         2: begin
            return ALL_ONES - RAND_W'($urandom_range(0, 600));
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Driver: new values go out on the falling edge. A raised start is held
   // until the core takes the transaction.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            start            <= 1'b1;
            req_mode         <= request_q[0].mode;
            req_random_value <= request_q[0].rnd;
            void'(request_q.pop_front());
         end else begin
            // idle: payload is junk while start is low
            start            <= 1'b0;
            req_mode         <= 1'($urandom_range(0, 1));
            req_random_value <= $urandom;
         end
      end
   end

   // Monitor: responses are checked before the transaction accepted at the
   // same edge is predicted, so back-to-back traffic keeps its order.
   always @(posedge clock) begin
      if (reset) begin
         taken = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               $error("response strobe with no transaction outstanding");
               errors++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_address !== want.address) begin
                  $error("address: expected %h, got %h", want.address, rsp_address);
                  errors++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %b, got %b", want.found, rsp_found);
                  errors++;
               end
               if (rsp_remaining !== want.remaining) begin
                  $error("remaining: expected %0d, got %0d", want.remaining, rsp_remaining);
                  errors++;
               end
            end
         end
         taken = start && !busy;
         if (taken) begin
            answer_q.insert(answer_q.size(),
                            predict_draw(mode_type'(req_mode), req_random_value));
         end
      end
   end

   // Watchdog: any cycle with a request or response transaction resets it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
      end
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("cidr_random_address_draw_core test failed");
         $finish;
      end
   end

   // Returns on a falling edge once every queued transaction has been taken
   // and answered and the core is idle. Checked on rising edges, where the
   // driver's start is settled.
   task automatic settle();
      do @(posedge clock);
      while (request_q.size() != 0 || start || busy || answer_q.size() != 0);
      @(negedge clock);
   endtask

   // APB write then read back. Starts on a falling edge, ends on one with the
   // bus released.
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_ADDR_W-1:0] where;
      logic [CSR_DATA_W-1:0] readback;
      where = CSR_ADDR_W'(4 * int'(idx));
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= where;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_BASE_HOST) begin
         host_reg = value;
         readback = value;
      end else begin
         prefix_reg = value[PREFIX_W-1:0];
         readback   = CSR_DATA_W'(value[PREFIX_W-1:0]);
      end
      if (prdata !== readback) begin
         $error("prdata: expected %h, got %h", readback, prdata);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_item(mode_type mode, logic [RAND_W-1:0] rnd);
      draw_request_type item;
      item.mode = mode;
      item.rnd  = rnd;
      request_q.insert(request_q.size(), item);
   endtask

   initial begin
      int prefix_plan [RANDOM_PHASES];
      int idle_plan [4];
      logic [ADDR_W-1:0] base;

      prefix_plan = '{28, 32, 26, 7, 24, 31, 33, 30, 63, 8};
      idle_plan   = '{0, 76, 0, 20};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset config: base 0, prefix 32; empty pool draws around a one-entry pool
      push_item(MODE_DRAW,    32'h0000_0000);
      push_item(MODE_RESTART, 32'hFFFF_FFFF);
      push_item(MODE_DRAW,    32'hFFFF_FFFF);
      push_item(MODE_DRAW,    32'h0000_0001);
      settle();

      // top of address space, four entry pool, leave one entry behind
      csr_write(CSR_BASE_HOST, 32'hFFFF_FFFF);
      csr_write(CSR_PREFIX_LEN, 32'(30));
      push_item(MODE_RESTART, 32'h0000_0000);
      push_item(MODE_DRAW,    32'h0000_0000);
      push_item(MODE_DRAW,    32'hFFFF_FFFF);
      push_item(MODE_DRAW,    32'h0000_0001);
      settle();

      // short prefix without refill: leftover offset on the unmasked base wraps
      csr_write(CSR_PREFIX_LEN, 32'hFFFF_FFC3);   // upper bits ignored, prefix 3
      push_item(MODE_DRAW,    32'h8000_0000);
      push_item(MODE_DRAW,    32'h0000_0005);
      push_item(MODE_RESTART, 32'h0000_0000);
      push_item(MODE_DRAW,    32'h0000_0007);
      push_item(MODE_DRAW,    32'h0000_0000);
      settle();

      // prefix 0 and prefix beyond 32
      csr_write(CSR_BASE_HOST, 32'h0A0B_0C0D);
      csr_write(CSR_PREFIX_LEN, 32'(0));
      push_item(MODE_RESTART, 32'h1234_5678);
      push_item(MODE_DRAW,    32'h8000_0000);
      settle();
      csr_write(CSR_PREFIX_LEN, 32'(63));
      push_item(MODE_RESTART, 32'h0000_0000);
      push_item(MODE_DRAW,    32'hFFFF_FFFF);
      settle();

      // largest block (clamped) and a /24: full pool refill
      csr_write(CSR_BASE_HOST, 32'hC0A8_1234);
      csr_write(CSR_PREFIX_LEN, 32'(8));
      push_item(MODE_RESTART, 32'h0000_0000);
      push_item(MODE_DRAW,    32'hFFFF_FFFF);
      push_item(MODE_DRAW,    32'h0000_0000);
      push_item(MODE_DRAW,    32'h1234_5678);
      settle();
      csr_write(CSR_PREFIX_LEN, 32'(24));
      push_item(MODE_RESTART, 32'h0000_0000);
      push_item(MODE_DRAW,    32'h0000_00FF);
      settle();

      // --- random phases ---
      // Mostly draws with rare restarts so small pools drain to empty; each
      // phase opens on the pool left by the previous config.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            3: begin
               base = ALL_ONES;
            end
            6: begin
               base = '0;
            end
            default: begin
               base = $urandom;
            end
         endcase
         csr_write(CSR_BASE_HOST, base);
         csr_write(CSR_PREFIX_LEN,
                   {6'($urandom_range(0, 3)), 26'd0} | 32'(prefix_plan[ph]));
         idle_pct = idle_plan[ph % 4];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 4) begin
               push_item(MODE_RESTART, $urandom);
            end else begin
               push_item(MODE_DRAW, pick_random_value());
            end
         end
         settle();
      end

      // drain margin of one full refill
      repeat (DEPTH + 40) @(negedge clock);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("cidr_random_address_draw_core test passed");
      end else begin
         $display("cidr_random_address_draw_core test failed");
      end
      $finish;
   end

endmodule
